// ===== hdl/dth_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline heap timer package
// Shared codes, widths, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dth_pkg;

  localparam int DL_W     = 48;
  localparam int TMO_W    = 32;
  localparam int ID_W     = 10;
  localparam int MAX_FIRE = 32;
  localparam int FIRE_W   = 6;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_FIRE   = 3'd2;
  localparam logic [2:0] OP_EXPIRE = 3'd3;
  localparam logic [2:0] OP_WAIT   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] K_FIRED = 2'd0;
  localparam logic [1:0] K_WAIT  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LOOK, S_RM, S_RM_LD, S_DN0, S_DN1, S_DN2, S_DN3,
    S_UP0, S_UP1, S_FIN, S_POST, S_EXP0, S_EXP1, S_WT0, S_WT1,
    S_CLR0, S_CLR1, S_END, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  id;
    logic [TMO_W-1:0] wait_ms;
    logic [1:0]       err;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/dth_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Heap slot memory
// One write port and one registered read port for deadline and owner.
// ----------------------------------------------------------------------------
`default_nettype none

module dth_slot_ram
  import dth_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic            clk,
  input  wire logic [AW-1:0]   rd_addr,
  output      logic [DL_W-1:0] rd_dl,
  output      logic [ID_W-1:0] rd_owner,
  input  wire logic            we,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [DL_W-1:0] wr_dl,
  input  wire logic [ID_W-1:0] wr_owner
);

  logic [DL_W+ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_dl, wr_owner};
    end
    {rd_dl, rd_owner} <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/dth_id_map.sv =====
// ----------------------------------------------------------------------------
// Timer id map
// Presence bit and heap slot per id, one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dth_id_map #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int SW    = 5
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output      logic          rd_present,
  output      logic [SW-1:0] rd_slot,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_present,
  input  wire logic [SW-1:0] wr_slot
);

  logic [SW:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_present, wr_slot};
    end
    {rd_present, rd_slot} <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/dth_sub_unit.sv =====
// ----------------------------------------------------------------------------
// Shared deadline subtractor
// Difference and borrow of two deadlines; serves every deadline compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dth_sub_unit
  import dth_pkg::*;
(
  input  wire logic [DL_W-1:0] a,
  input  wire logic [DL_W-1:0] b,
  output      logic [DL_W-1:0] diff,
  output      logic            borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

// ===== hdl/deadline_min_heap_timer.sv =====
// ----------------------------------------------------------------------------
// Deadline min-heap timer queue
// Binary min-heap of (deadline, id) with an id-to-slot map, run by a
// sequencer around one shared subtractor. One operation at a time: a
// lookup, then sifts that go level by level through the single slot
// memory read port. Each fired timer is removed and sifted in turn, a
// clear walks every pending timer, and every result waits out any output
// stall. After reset every id map entry (at most 1024) is cleared before
// the first item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_min_heap_timer
  import dth_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int MAX_IDS  = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [2:0]       op,
  input  wire logic [ID_W-1:0]  timer_id,
  input  wire logic [TMO_W-1:0] timeout_ms,
  input  wire logic [DL_W-1:0]  now_ms,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [1:0]       kind,
  output      logic [ID_W-1:0]  timer_id_res,
  output      logic [TMO_W-1:0] wait_ms,
  output      logic             has_timer,
  output      logic [1:0]       error_code,
  output      logic             last
);

  localparam int SW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int CIW       = SW + 2;
  localparam int MAP_DEPTH = (MAX_IDS < 1024) ? MAX_IDS : 1024;
  localparam int MW        = $clog2(MAP_DEPTH);

  state_t state, state_next, ret, ret_next;
  logic [2:0]       op_r, op_r_next;
  logic [ID_W-1:0]  id_r, id_r_next;
  logic [DL_W-1:0]  now_r, now_r_next, dl_r, dl_r_next;
  logic [CW-1:0]    count, count_next;
  logic [SW-1:0]    idx, idx_next, par, par_next, c_idx, c_idx_next;
  logic [DL_W-1:0]  mv_d, mv_d_next, c_d, c_d_next;
  logic [ID_W-1:0]  mv_o, mv_o_next, c_o, c_o_next, rem_o, rem_o_next;
  logic             moved, moved_next;
  logic [FIRE_W-1:0] fire_k, fire_k_next;
  res_t             res, res_next;
  logic [MW-1:0]    clr_addr, clr_addr_next;
  logic             out_load;

  logic [SW-1:0]    slot_ra, slot_wa;
  logic             slot_we;
  logic [DL_W-1:0]  rd_d, slot_wd;
  logic [ID_W-1:0]  rd_o, slot_wo;
  logic [MW-1:0]    map_ra, map_wa;
  logic             map_we, map_wp, map_rp;
  logic [SW-1:0]    map_ws, map_rs;
  logic [DL_W-1:0]  sub_a, sub_b, sub_diff;
  logic             sub_borrow;

  logic [DL_W:0]    dl_sum;
  logic [DL_W-1:0]  dl_sat;
  logic             id_ok;
  logic [CIW-1:0]   child;
  logic [CW-1:0]    cnt_m1;
  logic [SW-1:0]    up_par;

  dth_slot_ram #(.DEPTH(CAPACITY), .AW(SW)) u_slots (
    .clk      (clk),
    .rd_addr  (slot_ra),
    .rd_dl    (rd_d),
    .rd_owner (rd_o),
    .we       (slot_we),
    .wr_addr  (slot_wa),
    .wr_dl    (slot_wd),
    .wr_owner (slot_wo)
  );

  dth_id_map #(.DEPTH(MAP_DEPTH), .AW(MW), .SW(SW)) u_map (
    .clk        (clk),
    .rd_addr    (map_ra),
    .rd_present (map_rp),
    .rd_slot    (map_rs),
    .we         (map_we),
    .wr_addr    (map_wa),
    .wr_present (map_wp),
    .wr_slot    (map_ws)
  );

  dth_sub_unit u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign dl_sum = {1'b0, now_ms} + {{(DL_W + 1 - TMO_W){1'b0}}, timeout_ms};
  assign dl_sat = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];
  assign id_ok  = 32'(id_r) < MAX_IDS;
  assign child  = CIW'({idx, 1'b1});
  assign cnt_m1 = count - CW'(1);
  assign up_par = SW'((idx - SW'(1)) >> 1);

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    op_r_next     = op_r;
    id_r_next     = id_r;
    now_r_next    = now_r;
    dl_r_next     = dl_r;
    count_next    = count;
    idx_next      = idx;
    par_next      = par;
    c_idx_next    = c_idx;
    mv_d_next     = mv_d;
    mv_o_next     = mv_o;
    c_d_next      = c_d;
    c_o_next      = c_o;
    rem_o_next    = rem_o;
    moved_next    = moved;
    fire_k_next   = fire_k;
    res_next      = res;
    clr_addr_next = clr_addr;
    out_load      = 1'b0;
    in_ready      = 1'b0;
    slot_ra       = idx;
    slot_we       = 1'b0;
    slot_wa       = idx;
    slot_wd       = mv_d;
    slot_wo       = mv_o;
    map_ra        = timer_id[MW-1:0];
    map_we        = 1'b0;
    map_wa        = mv_o[MW-1:0];
    map_wp        = 1'b1;
    map_ws        = idx;
    sub_a         = mv_d;
    sub_b         = rd_d;
    unique case (state)
      S_INIT: begin
        map_we        = 1'b1;
        map_wa        = clr_addr;
        map_wp        = 1'b0;
        clr_addr_next = clr_addr + MW'(1);
        if (clr_addr == MW'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_r_next   = op;
          id_r_next   = timer_id;
          now_r_next  = now_ms;
          dl_r_next   = dl_sat;
          moved_next  = 1'b0;
          fire_k_next = '0;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        res_next   = '{kind: K_DONE, id: id_r, wait_ms: '0, err: ERR_NONE, last: 1'b1};
        ret_next   = S_IDLE;
        state_next = S_OUT;
        if (op_r == OP_ADD || op_r == OP_PUSH) begin
          if (!id_ok || (op_r == OP_PUSH && !map_rp)) begin
            res_next.kind = K_ERROR;
            res_next.err  = ERR_UNKNOWN;
          end else if (map_rp) begin
            idx_next   = map_rs;
            mv_d_next  = dl_r;
            mv_o_next  = id_r;
            state_next = S_DN0;
          end else if (count == CW'(CAPACITY)) begin
            res_next.kind = K_ERROR;
            res_next.err  = ERR_FULL;
          end else begin
            idx_next   = count[SW-1:0];
            count_next = count + CW'(1);
            mv_d_next  = dl_r;
            mv_o_next  = id_r;
            state_next = S_UP0;
          end
        end else if (op_r == OP_FIRE) begin
          if (id_ok && map_rp) begin
            idx_next   = map_rs;
            rem_o_next = id_r;
            state_next = S_RM;
          end
        end else if (op_r == OP_EXPIRE || op_r == OP_WAIT) begin
          state_next = S_EXP0;
        end else if (op_r == OP_CLEAR) begin
          idx_next   = '0;
          state_next = S_CLR0;
        end
      end
      S_RM: begin
        count_next = cnt_m1;
        map_we     = 1'b1;
        map_wa     = rem_o[MW-1:0];
        map_wp     = 1'b0;
        moved_next = 1'b0;
        if (CW'(idx) < cnt_m1) begin
          slot_ra    = cnt_m1[SW-1:0];
          state_next = S_RM_LD;
        end else begin
          state_next = S_POST;
        end
      end
      S_RM_LD: begin
        mv_d_next  = rd_d;
        mv_o_next  = rd_o;
        state_next = S_DN0;
      end
      S_DN0: begin
        if (child >= CIW'(count)) begin
          state_next = moved ? S_FIN : S_UP0;
        end else begin
          slot_ra    = child[SW-1:0];
          c_idx_next = child[SW-1:0];
          state_next = S_DN1;
        end
      end
      S_DN1: begin
        c_d_next = rd_d;
        c_o_next = rd_o;
        if (CIW'(c_idx) + CIW'(1) < CIW'(count)) begin
          slot_ra    = c_idx + SW'(1);
          state_next = S_DN2;
        end else begin
          state_next = S_DN3;
        end
      end
      S_DN2: begin
        sub_a = rd_d;
        sub_b = c_d;
        if (sub_borrow) begin
          c_d_next   = rd_d;
          c_o_next   = rd_o;
          c_idx_next = c_idx + SW'(1);
        end
        state_next = S_DN3;
      end
      S_DN3: begin
        sub_a = c_d;
        sub_b = mv_d;
        if (sub_borrow) begin
          slot_we    = 1'b1;
          slot_wd    = c_d;
          slot_wo    = c_o;
          map_we     = 1'b1;
          map_wa     = c_o[MW-1:0];
          idx_next   = c_idx;
          moved_next = 1'b1;
          state_next = S_DN0;
        end else begin
          state_next = moved ? S_FIN : S_UP0;
        end
      end
      S_UP0: begin
        if (idx == '0) begin
          state_next = S_FIN;
        end else begin
          slot_ra    = up_par;
          par_next   = up_par;
          state_next = S_UP1;
        end
      end
      S_UP1: begin
        if (sub_borrow) begin
          slot_we    = 1'b1;
          slot_wd    = rd_d;
          slot_wo    = rd_o;
          map_we     = 1'b1;
          map_wa     = rd_o[MW-1:0];
          idx_next   = par;
          state_next = S_UP0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        slot_we    = 1'b1;
        map_we     = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if (op_r == OP_ADD || op_r == OP_PUSH) begin
          state_next = S_END;
        end else begin
          res_next   = '{kind: K_FIRED, id: rem_o, wait_ms: '0, err: ERR_NONE, last: 1'b0};
          ret_next   = (op_r == OP_FIRE) ? S_END : S_EXP0;
          state_next = S_OUT;
        end
      end
      S_EXP0: begin
        if (count == '0 || fire_k == FIRE_W'(MAX_FIRE)) begin
          state_next = (op_r == OP_WAIT) ? S_WT0 : S_END;
        end else begin
          slot_ra    = '0;
          state_next = S_EXP1;
        end
      end
      S_EXP1: begin
        sub_a = now_r;
        sub_b = rd_d;
        if (!sub_borrow) begin
          rem_o_next  = rd_o;
          idx_next    = '0;
          fire_k_next = fire_k + FIRE_W'(1);
          state_next  = S_RM;
        end else begin
          state_next = (op_r == OP_WAIT) ? S_WT0 : S_END;
        end
      end
      S_WT0: begin
        if (count == '0) begin
          res_next   = '{kind: K_WAIT, id: id_r, wait_ms: '1, err: ERR_NONE, last: 1'b1};
          ret_next   = S_IDLE;
          state_next = S_OUT;
        end else begin
          slot_ra    = '0;
          state_next = S_WT1;
        end
      end
      S_WT1: begin
        sub_a    = rd_d;
        sub_b    = now_r;
        res_next = '{kind: K_WAIT, id: id_r, wait_ms: '0, err: ERR_NONE, last: 1'b1};
        if (!sub_borrow) begin
          res_next.wait_ms = (|sub_diff[DL_W-1:TMO_W]) ? '1 : sub_diff[TMO_W-1:0];
        end
        ret_next   = S_IDLE;
        state_next = S_OUT;
      end
      S_CLR0: begin
        if (count == '0) begin
          state_next = S_END;
        end else begin
          slot_ra    = idx;
          state_next = S_CLR1;
        end
      end
      S_CLR1: begin
        map_we = 1'b1;
        map_wa = rd_o[MW-1:0];
        map_wp = 1'b0;
        if (CIW'(idx) + CIW'(1) == CIW'(count)) begin
          count_next = '0;
          state_next = S_END;
        end else begin
          idx_next   = idx + SW'(1);
          state_next = S_CLR0;
        end
      end
      S_END: begin
        res_next   = '{kind: K_DONE, id: id_r, wait_ms: '0, err: ERR_NONE, last: 1'b1};
        ret_next   = S_IDLE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ret;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      count    <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret    <= ret_next;
    op_r   <= op_r_next;
    id_r   <= id_r_next;
    now_r  <= now_r_next;
    dl_r   <= dl_r_next;
    idx    <= idx_next;
    par    <= par_next;
    c_idx  <= c_idx_next;
    mv_d   <= mv_d_next;
    mv_o   <= mv_o_next;
    c_d    <= c_d_next;
    c_o    <= c_o_next;
    rem_o  <= rem_o_next;
    moved  <= moved_next;
    fire_k <= fire_k_next;
    res    <= res_next;
    if (out_load) begin
      kind         <= res.kind;
      timer_id_res <= res.id;
      wait_ms      <= res.wait_ms;
      has_timer    <= (count != '0);
      error_code   <= res.err;
      last         <= res.last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("pending count above capacity");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation runs");

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_ERROR |-> last && error_code != ERR_NONE)
    else $error("error beat not final or without code");

  a_wait_only_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_WAIT |-> wait_ms == '0)
    else $error("wait value on a non-wait beat");

endmodule

`default_nettype wire
